@@ hdl/height_band_window_classifier_core_assert.svh @@
// Assertion macros shared by the height band window classifier RTL.
`ifndef HEIGHT_BAND_WINDOW_CLASSIFIER_CORE_ASSERT_SVH
`define HEIGHT_BAND_WINDOW_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define HBWC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Checked at every edge; the property guards itself against reset.
`define HBWC_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBWC_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define HBWC_ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

@@ hdl/hbwc_pkg.sv @@
// Types, constants and the band classifier shared by the classifier RTL.
package hbwc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BAND_W   = 3;
  localparam int LEVEL_N  = 6;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int REG_IW   = 3;

  typedef logic [BAND_W-1:0]   band_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  localparam band_t BAND_REF     = 3'd0;
  localparam band_t BAND_HOLE    = 3'd1;
  localparam band_t BAND_SURFACE = 3'd2;
  localparam band_t BAND_LOW     = 3'd3;
  localparam band_t BAND_HIGH    = 3'd4;
  localparam band_t BAND_INVALID = 3'd5;
  localparam band_t BAND_NONE    = 3'd6;

  // Register indexes on the configuration port.
  localparam logic [REG_IW-1:0] REG_REF_LEVEL     = 3'd0;
  localparam logic [REG_IW-1:0] REG_HOLE_LEVEL    = 3'd1;
  localparam logic [REG_IW-1:0] REG_SURFACE_LEVEL = 3'd2;
  localparam logic [REG_IW-1:0] REG_LOW_LEVEL     = 3'd3;
  localparam logic [REG_IW-1:0] REG_HIGH_LEVEL    = 3'd4;
  localparam logic [REG_IW-1:0] REG_INVALID_LEVEL = 3'd5;
  localparam logic [REG_IW-1:0] REG_TOLERANCE     = 3'd6;
  localparam logic [REG_IW-1:0] REG_LAST          = REG_TOLERANCE;

  typedef struct packed {
    logic [LEVEL_N-1:0][SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0]              tol;
  } cfg_t;

  // First band whose level lies strictly within the tolerance, else none.
  function automatic band_t classify(sample_t s, cfg_t c);
    band_t   code;
    sample_t diff;
    code = BAND_NONE;
    for (int b = LEVEL_N - 1; b >= 0; b--) begin
      diff = (s >= c.level[b]) ? (s - c.level[b]) : (c.level[b] - s);
      if (diff < c.tol) begin
        code = band_t'(b);
      end
    end
    return code;
  endfunction

endpackage

@@ hdl/hbwc_in_if.sv @@
// Sample input channel: valid/ready handshake carrying one sample word.
interface hbwc_in_if
  import hbwc_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/hbwc_out_if.sv @@
// Result channel: valid/ready handshake carrying one classification word.
interface hbwc_out_if
  import hbwc_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    report;
  band_t   band;
  logic    window_stable;
  sample_t lowest_sample;

  modport source (output valid, output report, output band, output window_stable,
                  output lowest_sample, input ready);
  modport sink   (input valid, input report, input band, input window_stable,
                  input lowest_sample, output ready);
endinterface

@@ hdl/hbwc_cfg.sv @@
// APB-style register file holding the band levels and the tolerance.
module hbwc_cfg
  import hbwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam int REG_N = LEVEL_N + 1;

  logic [REG_N-1:0][SAMPLE_W-1:0] regs_r;
  logic [REG_IW-1:0]              idx;
  logic                           idx_ok;
  logic                           wr_en;

  assign idx    = paddr[CFG_AW-1:2];
  assign idx_ok = (idx <= REG_LAST);
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (wr_en) begin
      regs_r[idx] <= pwdata[SAMPLE_W-1:0];
    end
  end

  assign prdata = idx_ok ? {{(CFG_DW-SAMPLE_W){1'b0}}, regs_r[idx]} : '0;

  always_comb begin
    for (int b = 0; b < LEVEL_N; b++) begin
      cfg.level[b] = regs_r[b];
    end
    cfg.tol = regs_r[REG_TOLERANCE];
  end

endmodule

@@ hdl/hbwc_win_mem.sv @@
// Sample window memory with one write and one registered read port.
module hbwc_win_mem
  import hbwc_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sample_t       wr_data,
  input  logic [AW-1:0] rd_addr,
  output sample_t       rd_data
);

  sample_t            mem [DEPTH];
  logic [DEPTH-1:0]   written_r;
  sample_t            rd_raw_r;
  logic               rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw_r <= mem[rd_addr];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      rd_ok_r <= written_r[rd_addr];
    end
  end

  assign rd_data = rd_ok_r ? rd_raw_r : '0;

endmodule

@@ hdl/height_band_window_classifier_core.sv @@
// Top level of the height band window classifier.
//
// Each sample word taken on in_ch is classified into the first of six
// calibrated bands whose level lies strictly within the tolerance; with no
// match the current band is kept. The sample is written into a ring window
// held in a one-port-write, one-port-read memory, and the lowest sample since
// reset is tracked. The sequencer then reads every window entry back, one per
// cycle, classifies it with the current levels and checks that all entries
// agree. A stable window sets report if the current band differs from the last
// reported band. One result word per sample goes out on out_ch.
// The scan uses the window memory's single read port. Once the result is
// loaded the block returns to idle; no new sample is taken before then.
// The result sits in an output register, so a new sample is accepted while
// the receiver stalls; a second result waits until the first is taken.
// Reset clears the control state, the window (reads as zero until written),
// the write pointer, sets three bands to none, the lowest sample to all ones.
// The user is to write the levels and tolerance over the APB-style port only
// while idle; the block itself does not enforce it.
`include "height_band_window_classifier_core_assert.svh"

module height_band_window_classifier_core
  import hbwc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  hbwc_in_if.sink           in_ch,
  hbwc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  cfg_t cfg;

  hbwc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t        state_r, state_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  band_t         cur_band_r, cur_band_nxt;
  band_t         rep_band_r, rep_band_nxt;
  band_t         first_r, first_nxt;
  sample_t       lowest_r, lowest_nxt;
  logic          stable_r, stable_nxt;
  logic          rsp_vld_r, rsp_first_r, rsp_last_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_report_r, out_stable_r;
  band_t         out_band_r;
  sample_t       out_lowest_r;

  logic    in_acc;
  logic    issue;
  logic    out_load;
  band_t   smp_band;
  band_t   rsp_band;
  sample_t rd_data;

  hbwc_win_mem #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_win_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_addr (wr_idx_r),
    .wr_data (in_ch.sample),
    .rd_addr (rd_cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign smp_band    = classify(in_ch.sample, cfg);
  assign rsp_band    = classify(rd_data, cfg);
  assign issue       = (state_r == S_SCAN) && (rd_cnt_r != CW'(WINDOW_DEPTH));
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    wr_idx_nxt   = wr_idx_r;
    rd_cnt_nxt   = rd_cnt_r;
    cur_band_nxt = cur_band_r;
    rep_band_nxt = rep_band_r;
    first_nxt    = first_r;
    lowest_nxt   = lowest_r;
    stable_nxt   = stable_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (smp_band != BAND_NONE) begin
            cur_band_nxt = smp_band;
          end
          if (in_ch.sample < lowest_r) begin
            lowest_nxt = in_ch.sample;
          end
          wr_idx_nxt = (wr_idx_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
          rd_cnt_nxt = '0;
          stable_nxt = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        // Read data arrives in the cycle after its address.
        if (rsp_vld_r) begin
          if (rsp_first_r) begin
            first_nxt = rsp_band;
          end else if (rsp_band != first_r) begin
            stable_nxt = 1'b0;
          end
          if (rsp_last_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          if (stable_r) begin
            rep_band_nxt = cur_band_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_cnt_r    <= '0;
      cur_band_r  <= BAND_NONE;
      rep_band_r  <= BAND_NONE;
      first_r     <= BAND_NONE;
      lowest_r    <= '1;
      stable_r    <= 1'b0;
      rsp_vld_r   <= 1'b0;
      rsp_first_r <= 1'b0;
      rsp_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      cur_band_r  <= cur_band_nxt;
      rep_band_r  <= rep_band_nxt;
      first_r     <= first_nxt;
      lowest_r    <= lowest_nxt;
      stable_r    <= stable_nxt;
      rsp_vld_r   <= issue;
      rsp_first_r <= issue && (rd_cnt_r == '0);
      rsp_last_r  <= issue && (rd_cnt_r == CW'(WINDOW_DEPTH - 1));
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_report_r <= stable_r && (cur_band_r != rep_band_r);
      out_band_r   <= cur_band_r;
      out_stable_r <= stable_r;
      out_lowest_r <= lowest_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.report        = out_report_r;
  assign out_ch.band          = out_band_r;
  assign out_ch.window_stable = out_stable_r;
  assign out_ch.lowest_sample = out_lowest_r;

  `HBWC_ASSERT_RST(a_accept_starts_scan, clk, rst_n,
    in_acc |=> (state_r == S_SCAN), "accepted sample did not start a window scan")
  `HBWC_ASSERT_RST(a_report_needs_stable, clk, rst_n,
    out_valid_r |-> (!out_report_r || out_stable_r), "report raised on unstable window")
  `HBWC_ASSERT_RST(a_wr_idx_range, clk, rst_n,
    wr_idx_r <= AW'(WINDOW_DEPTH - 1), "window write pointer out of range")
  `HBWC_ASSERT_ANY(a_lowest_monotonic, clk,
    (rst_n && $past(rst_n)) |-> (lowest_r <= $past(lowest_r)), "lowest sample rose")

endmodule
